// ===== rtl/drkd_pkg.sv =====
`timescale 1ns / 1ps

package drkd_pkg;

  // Field widths of the stream words
  localparam int ROW_W      = 2;
  localparam int SCAN_W     = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int LED_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  // Row that carries the knob pins
  localparam logic [ROW_W-1:0] KNOB_ROW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_LOCK = 3'd4;

  // Panel modes
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_LAMP_TEST = 2'd1;
  localparam logic [1:0] MODE_ALL_TEST  = 2'd2;
  localparam logic [1:0] MODE_POWERLESS = 2'd3;

  typedef logic [1:0] move_t;
  localparam move_t MOVE_NONE = 2'd0;
  localparam move_t MOVE_CW   = 2'd1;
  localparam move_t MOVE_CCW  = 2'd2;

  // Step decode, indexed by {previous code, current code}
  localparam move_t MOVE_TABLE [16] = '{
    MOVE_NONE, MOVE_CCW,  MOVE_CW,   MOVE_NONE,
    MOVE_CW,   MOVE_NONE, MOVE_NONE, MOVE_CCW,
    MOVE_CCW,  MOVE_NONE, MOVE_NONE, MOVE_CW,
    MOVE_NONE, MOVE_CW,   MOVE_CCW,  MOVE_NONE
  };

  localparam logic [2:0] ADDR_CODE_TABLE [8] = '{3'd7, 3'd4, 3'd6, 3'd3,
                                                 3'd1, 3'd0, 3'd2, 3'd5};
  localparam logic [1:0] DATA_CODE_TABLE [4] = '{2'd3, 2'd2, 2'd0, 2'd1};

  localparam logic [LED_W-1:0] ALL_LEDS = 12'hFC0;

  // Normal mode feedback LEDs per knob position
  localparam logic [LED_W-1:0] ADDR_LED_ROW4 [8] = '{
    12'h000, 12'h200, 12'h100, 12'h080, 12'h040, 12'h000, 12'h000, 12'h000};
  localparam logic [LED_W-1:0] ADDR_LED_ROW5 [8] = '{
    12'h200, 12'h000, 12'h000, 12'h000, 12'h000, 12'h040, 12'h080, 12'h100};
  localparam logic [LED_W-1:0] DATA_LED_ROW4 [4] = '{
    12'h800, 12'h400, 12'h000, 12'h000};
  localparam logic [LED_W-1:0] DATA_LED_ROW5 [4] = '{
    12'h000, 12'h000, 12'h400, 12'h800};

endpackage

// ===== rtl/dual_rotary_knob_decoder_top.sv =====
`timescale 1ns / 1ps

// An accepted row-2 word gives its result word on out_* in the next cycle.
// Throughput: one input word per cycle while out_tready keeps the output moving;
// the output register frees itself in the same cycle it is taken.
// Scans of other rows are taken and dropped without a result.
// Reset (rst_n low, synchronous): output empty, counters and codes cleared,
// first-scan flag set, registers at their defaults (start positions 1).
module dual_rotary_knob_decoder_top #(
  parameter int STEPS_PER_POSITION = 4,
  parameter int ADDR_POSITIONS     = 8,
  parameter int DATA_POSITIONS     = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [drkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [drkd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // scan stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] scan_bits, [12] lamp_test_switch, [15:13] zero
  input  logic [drkd_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] row_index
  input  logic [drkd_pkg::ROW_W-1:0]          in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] addr_position, [4:3] data_position, [7:5] addr_select_code,
  // [9:8] data_select_code, [10] lock_switch, [12:11] effective_mode,
  // [24:13] led_row4_bits, [36:25] led_row5_bits, [39:37] zero
  output logic [drkd_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import drkd_pkg::*;

  // Each counter is kept as a position and a sub-step within that position,
  // which is the same as one counter modulo STEPS*POSITIONS.
  localparam int SW  = (STEPS_PER_POSITION > 1) ? $clog2(STEPS_PER_POSITION) : 1;
  localparam int APW = $clog2(ADDR_POSITIONS);
  localparam int DPW = $clog2(DATA_POSITIONS);
  localparam logic [SW-1:0]  SUB_LAST = SW'(STEPS_PER_POSITION - 1);
  localparam logic [APW:0]   A_LIMIT  = (APW+1)'(ADDR_POSITIONS);
  localparam logic [APW-1:0] A_LAST   = APW'(ADDR_POSITIONS - 1);
  localparam logic [DPW:0]   D_LIMIT  = (DPW+1)'(DATA_POSITIONS);
  localparam logic [DPW-1:0] D_LAST   = DPW'(DATA_POSITIONS - 1);

  // configuration registers
  logic [2:0] addr_start_r;
  logic [1:0] data_start_r;
  logic       reverse_r;
  logic [1:0] panel_mode_r;
  logic       panel_lock_r;

  // knob state
  logic [APW-1:0] addr_pos_r, addr_pos_nxt;
  logic [SW-1:0]  addr_sub_r, addr_sub_nxt;
  logic [DPW-1:0] data_pos_r, data_pos_nxt;
  logic [SW-1:0]  data_sub_r, data_sub_nxt;
  logic [1:0]     addr_prev_r, data_prev_r;
  logic           first_scan_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic       in_fire, knob_fire;
  logic [1:0] acode, dcode;
  move_t      amove, dmove;
  logic [4:0] apos_ext, dpos_ext;
  logic [2:0] apos3, asel;
  logic [1:0] dpos2, dsel, mode;
  logic [LED_W-1:0] row4, row5;

  // Start position reduced modulo the number of positions (input below 8)
  function automatic logic [3:0] wrap_start(input logic [3:0] start,
                                            input logic [4:0] limit);
    logic [4:0] v;
    v = {1'b0, start};
    for (int i = 0; i < 4; i++) begin
      if (v >= limit) begin
        v = v - limit;
      end
    end
    return v[3:0];
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign knob_fire = in_fire && (in_tuser == KNOB_ROW);

  assign acode = in_tdata[9:8];
  assign dcode = in_tdata[11:10];

  // Decode the step and flip it when counting backwards
  always_comb begin
    amove = MOVE_TABLE[{addr_prev_r, acode}];
    dmove = MOVE_TABLE[{data_prev_r, dcode}];
    if (reverse_r) begin
      if (amove == MOVE_CW) begin
        amove = MOVE_CCW;
      end else if (amove == MOVE_CCW) begin
        amove = MOVE_CW;
      end
      if (dmove == MOVE_CW) begin
        dmove = MOVE_CCW;
      end else if (dmove == MOVE_CCW) begin
        dmove = MOVE_CW;
      end
    end
  end

  // Advance the address knob counter
  always_comb begin
    addr_pos_nxt = addr_pos_r;
    addr_sub_nxt = addr_sub_r;
    if (first_scan_r) begin
      addr_pos_nxt = APW'(wrap_start({1'b0, addr_start_r}, 5'(ADDR_POSITIONS)));
      addr_sub_nxt = '0;
    end else if (amove == MOVE_CW) begin
      if (addr_sub_r == SUB_LAST) begin
        addr_sub_nxt = '0;
        addr_pos_nxt = ({1'b0, addr_pos_r} + 1'b1 == A_LIMIT) ? '0 : addr_pos_r + 1'b1;
      end else begin
        addr_sub_nxt = addr_sub_r + 1'b1;
      end
    end else if (amove == MOVE_CCW) begin
      if (addr_sub_r == '0) begin
        addr_sub_nxt = SUB_LAST;
        addr_pos_nxt = (addr_pos_r == '0) ? A_LAST : addr_pos_r - 1'b1;
      end else begin
        addr_sub_nxt = addr_sub_r - 1'b1;
      end
    end
  end

  // Advance the data knob counter
  always_comb begin
    data_pos_nxt = data_pos_r;
    data_sub_nxt = data_sub_r;
    if (first_scan_r) begin
      data_pos_nxt = DPW'(wrap_start({2'b00, data_start_r}, 5'(DATA_POSITIONS)));
      data_sub_nxt = '0;
    end else if (dmove == MOVE_CW) begin
      if (data_sub_r == SUB_LAST) begin
        data_sub_nxt = '0;
        data_pos_nxt = ({1'b0, data_pos_r} + 1'b1 == D_LIMIT) ? '0 : data_pos_r + 1'b1;
      end else begin
        data_sub_nxt = data_sub_r + 1'b1;
      end
    end else if (dmove == MOVE_CCW) begin
      if (data_sub_r == '0) begin
        data_sub_nxt = SUB_LAST;
        data_pos_nxt = (data_pos_r == '0) ? D_LAST : data_pos_r - 1'b1;
      end else begin
        data_sub_nxt = data_sub_r - 1'b1;
      end
    end
  end

  // Build the result word from the updated positions
  always_comb begin
    apos_ext = 5'(addr_pos_nxt);
    dpos_ext = 5'(data_pos_nxt);
    apos3    = apos_ext[2:0];
    dpos2    = dpos_ext[1:0];
    asel     = ADDR_CODE_TABLE[apos3];
    dsel     = DATA_CODE_TABLE[dpos2];
    mode     = in_tdata[12] ? panel_mode_r : MODE_LAMP_TEST;
    row4     = '0;
    row5     = '0;
    case (mode)
      MODE_NORMAL: begin
        // positions past the LED tables light nothing
        if (apos_ext < 5'd8) begin
          row4 = row4 | ADDR_LED_ROW4[apos3];
          row5 = row5 | ADDR_LED_ROW5[apos3];
        end
        if (dpos_ext < 5'd4) begin
          row4 = row4 | DATA_LED_ROW4[dpos2];
          row5 = row5 | DATA_LED_ROW5[dpos2];
        end
      end
      MODE_LAMP_TEST, MODE_ALL_TEST: begin
        row4 = ALL_LEDS;
        row5 = ALL_LEDS;
      end
      default: begin
        row4 = '0;
        row5 = '0;
      end
    endcase
    out_data_nxt = {3'b000, row5, row4, mode, panel_lock_r, dsel, asel, dpos2, apos3};
  end

  // Load on a knob scan, drop the word once taken, otherwise hold
  always_comb begin
    if (knob_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_start_r <= 3'd1;
      data_start_r <= 2'd1;
      reverse_r    <= 1'b0;
      panel_mode_r <= MODE_NORMAL;
      panel_lock_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ADDR_START: addr_start_r <= cfg_wdata[2:0];
        CFG_DATA_START: data_start_r <= cfg_wdata[1:0];
        CFG_REVERSE:    reverse_r    <= cfg_wdata[0];
        CFG_PANEL_MODE: panel_mode_r <= cfg_wdata[1:0];
        CFG_PANEL_LOCK: panel_lock_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_pos_r   <= '0;
      addr_sub_r   <= '0;
      data_pos_r   <= '0;
      data_sub_r   <= '0;
      addr_prev_r  <= '0;
      data_prev_r  <= '0;
      first_scan_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (knob_fire) begin
        addr_pos_r   <= addr_pos_nxt;
        addr_sub_r   <= addr_sub_nxt;
        data_pos_r   <= data_pos_nxt;
        data_sub_r   <= data_sub_nxt;
        addr_prev_r  <= acode;
        data_prev_r  <= dcode;
        first_scan_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (knob_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/drkd_checker.sv =====
`timescale 1ns / 1ps

module drkd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [drkd_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [drkd_pkg::ROW_W-1:0]      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [drkd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import drkd_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  // A knob-row scan gives a result in the next cycle
  a_knob_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KNOB_ROW |=> out_tvalid)
    else $error("knob scan gave no result");

  // Other rows give none, once any earlier word is gone
  a_other_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != KNOB_ROW && (!out_tvalid || out_tready)
    |=> !out_tvalid)
    else $error("result from a non-knob row");

  // Lamp switch low forces lamp test with every LED lit
  a_lamp_test: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KNOB_ROW && !in_tdata[12]
    |=> out_tdata[12:11] == MODE_LAMP_TEST && out_tdata[24:13] == ALL_LEDS
        && out_tdata[36:25] == ALL_LEDS)
    else $error("lamp test override not applied");

  // Powerless mode lights nothing
  a_powerless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12:11] == MODE_POWERLESS |-> out_tdata[36:13] == 24'd0)
    else $error("LEDs lit in powerless mode");

endmodule

bind dual_rotary_knob_decoder_top drkd_checker u_drkd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
